### src/lae_pkg.sv
// Shared types and constants of the life automaton engine.
package lae_pkg;

   // Item kinds carried in the request word.
   localparam logic [1:0] KindWrite = 2'd0;
   localparam logic [1:0] KindStep  = 2'd1;
   localparam logic [1:0] KindRead  = 2'd2;

   // Neighbor counts of rule B3/S23.
   localparam logic [3:0] BirthCount   = 4'd3;
   localparam logic [3:0] SurviveCount = 4'd2;

   // One request word.
   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  row_index;
      logic [63:0] row_cells;
   } req_type;

   // One response word.
   typedef struct packed {
      logic [63:0] read_cells;
      logic [15:0] generation;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      StClear,
      StIdle,
      StRead,
      StStep
   } state_type;

endpackage

### src/lae_ram.sv
// Generic memory with one write port and one registered read port.
module lae_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read both take effect at the clock edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/lae_row_unit.sv
// Next-generation evaluator for one row, given the rows above and below.
module lae_row_unit
   import lae_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0] row_up,
   input  logic [WIDTH-1:0] row_mid,
   input  logic [WIDTH-1:0] row_down,
   input  logic             edge_row,
   output logic [WIDTH-1:0] row_next
);

   // The first and last columns are border cells and always die.
   assign row_next[0]       = 1'b0;
   assign row_next[WIDTH-1] = 1'b0;

   // Every interior column counts its eight neighbors independently.
   for (genvar x = 1; x < WIDTH - 1; x++) begin : g_col
      logic [7:0] nbrs;
      logic [3:0] count;

      assign nbrs  = {row_up[x+1:x-1], row_down[x+1:x-1], row_mid[x+1], row_mid[x-1]};
      assign count = 4'($countones(nbrs));
      assign row_next[x] = !edge_row &&
                           ((count == BirthCount) || (row_mid[x] && count == SurviveCount));
   end

endmodule

### src/life_automaton_engine_core.sv
// Top level of the life automaton engine: sequencer, row window and grid memory.
//
// The engine holds a GRID_HEIGHT by GRID_WIDTH grid of cells that evolves under
// rule B3/S23, with every border cell forced dead on each step. Each request word
// gives exactly one response word. A row write or an unused kind answers in the cycle
// after it is taken; a row read answers through the registered read of the grid memory
// and then the response register. A step sweeps the grid once through the single row
// evaluator, one row per cycle behind a three-stage read, window and write-back
// pipeline. One word is in flight at a time. After reset the engine clears the grid
// memory one row per cycle and takes no request word until that is done.
module life_automaton_engine_core
   import lae_pkg::*;
#(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(GRID_HEIGHT);
   localparam int CW = $clog2(GRID_HEIGHT + 1);

   state_type state_ff, state_in;

   logic [CW-1:0]         iss_cnt_ff, iss_cnt_in;
   logic                  iss_on_ff, iss_on_in;
   logic                  feed_vld_ff, feed_vld_in;
   logic [CW-1:0]         feed_idx_ff, feed_idx_in;
   logic [GRID_WIDTH-1:0] win_ff [3];
   logic [GRID_WIDTH-1:0] win_in [3];
   logic                  win_vld_ff, win_vld_in;
   logic [CW-1:0]         win_idx_ff, win_idx_in;
   logic [15:0]           gen_ff, gen_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [GRID_WIDTH-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [GRID_WIDTH-1:0] rd_data;
   logic [GRID_WIDTH-1:0] feed_row;
   logic [GRID_WIDTH-1:0] row_next;
   logic [CW-1:0]         wb_idx;
   logic                  wb_edge;
   logic                  req_fire;
   logic                  row_in_range;

   // Grid memory, one word per row.
   lae_ram #(
      .WIDTH (GRID_WIDTH),
      .DEPTH (GRID_HEIGHT)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared row evaluator, used once per row of a step.
   lae_row_unit #(
      .WIDTH (GRID_WIDTH)
   ) u_row (
      .row_up   (win_ff[0]),
      .row_mid  (win_ff[1]),
      .row_down (win_ff[2]),
      .edge_row (wb_edge),
      .row_next (row_next)
   );

   // Write-back row is one behind the newest row in the window.
   assign wb_idx   = win_idx_ff - 1'b1;
   assign wb_edge  = (win_idx_ff == CW'(1)) || (win_idx_ff == CW'(GRID_HEIGHT));
   assign feed_row = (feed_idx_ff == CW'(GRID_HEIGHT)) ? '0 : rd_data;

   assign row_in_range = 32'(req_data.row_index) < 32'(GRID_HEIGHT);
   assign req_ready    = (state_ff == StIdle) && (!rsp_valid_ff || rsp_ready);
   assign req_fire     = req_valid && req_ready;

   // Next state, sweep pipeline and memory port control.
   always_comb begin
      state_in    = state_ff;
      iss_cnt_in  = iss_cnt_ff;
      iss_on_in   = iss_on_ff;
      feed_vld_in = 1'b0;
      feed_idx_in = feed_idx_ff;
      win_in      = win_ff;
      win_vld_in  = 1'b0;
      win_idx_in  = win_idx_ff;
      gen_in      = gen_ff;
      rd_ok_in    = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en       = 1'b0;
      wr_addr     = AW'(req_data.row_index);
      wr_data     = req_data.row_cells[GRID_WIDTH-1:0];
      rd_addr     = AW'(req_data.row_index);

      case (state_ff)
         StClear: begin
            wr_en      = 1'b1;
            wr_addr    = iss_cnt_ff[AW-1:0];
            wr_data    = '0;
            iss_cnt_in = iss_cnt_ff + 1'b1;
            if (iss_cnt_ff == CW'(GRID_HEIGHT - 1)) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            if (req_fire) begin
               case (req_data.kind)
                  KindWrite: begin
                     wr_en        = row_in_range;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{read_cells: '0, generation: gen_ff};
                  end
                  KindStep: begin
                     iss_cnt_in = '0;
                     iss_on_in  = 1'b1;
                     win_in[0]  = '0;
                     win_in[1]  = '0;
                     win_in[2]  = '0;
                     state_in   = StStep;
                  end
                  KindRead: begin
                     rd_ok_in = row_in_range;
                     state_in = StRead;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{read_cells: '0, generation: gen_ff};
                  end
               endcase
            end
         end
         StRead: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{read_cells: rd_ok_ff ? 64'(rd_data) : '0, generation: gen_ff};
            state_in     = StIdle;
         end
         StStep: begin
            // Read stage: rows 0 to GRID_HEIGHT-1, then one empty row below the grid.
            rd_addr = iss_cnt_ff[AW-1:0];
            if (iss_on_ff) begin
               feed_vld_in = 1'b1;
               feed_idx_in = iss_cnt_ff;
               iss_cnt_in  = iss_cnt_ff + 1'b1;
               iss_on_in   = iss_cnt_ff != CW'(GRID_HEIGHT);
            end
            // Window stage: shift the arriving row in at the bottom.
            if (feed_vld_ff) begin
               win_in[0]  = win_ff[1];
               win_in[1]  = win_ff[2];
               win_in[2]  = feed_row;
               win_vld_in = 1'b1;
               win_idx_in = feed_idx_ff;
            end
            // Write-back stage: the middle row of the window gets its next value.
            if (win_vld_ff && win_idx_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = wb_idx[AW-1:0];
               wr_data = row_next;
               if (win_idx_ff == CW'(GRID_HEIGHT)) begin
                  gen_in       = gen_ff + 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{read_cells: '0, generation: gen_ff + 1'b1};
                  state_in     = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_cnt_ff   <= '0;
         iss_on_ff    <= 1'b0;
         feed_vld_ff  <= 1'b0;
         win_vld_ff   <= 1'b0;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         iss_cnt_ff   <= iss_cnt_in;
         iss_on_ff    <= iss_on_in;
         feed_vld_ff  <= feed_vld_in;
         win_vld_ff   <= win_vld_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      feed_idx_ff <= feed_idx_in;
      win_ff      <= win_in;
      win_idx_ff  <= win_idx_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The clearing pass takes no word and gives none.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == StClear |-> !req_ready && !rsp_valid)
      else $error("request or response active during clearing pass");

   // Border rows are always written back dead.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StStep && wr_en && wb_edge) |-> wr_data == '0)
      else $error("border row written back alive");

   // During a sweep the write-back row never collides with the row being read.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StStep && wr_en && iss_on_ff && iss_cnt_ff < CW'(GRID_HEIGHT))
      |-> wr_addr != rd_addr)
      else $error("sweep wrote a row that is still to be read");

   // A finished step advances the generation count by one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StStep && state_in == StIdle) |=> gen_ff == $past(gen_ff) + 16'd1)
      else $error("generation count did not advance on step");

endmodule

### verif/life_automaton_engine_core_checker.sv
`timescale 1ns / 1ps
// Checker for the life automaton engine: it keeps its own grid, predicts every response word and compares.
module life_automaton_engine_core_checker
   import lae_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count
);

   localparam int GridRows = 64;
   localparam int GridCols = 64;

   // Shadow copy of the cell grid and the generation counter.
   logic [GridCols-1:0] life_rows [GridRows];
   logic [15:0]         generation_tally;

   // Response words that the engine still owes, oldest first.
   rsp_type owed_words [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // Replaces the grid by its next generation under B3/S23.
   // Cells on the outer border always end up dead.
   function automatic void evolve_grid();
      logic [GridCols-1:0] prior [GridRows];
      logic [GridCols-1:0] fresh;
      int y, x, dy, dx, live;
      prior = life_rows;
      for (y = 0; y < GridRows; y++) begin
         fresh = '0;
         if (y > 0 && y < GridRows - 1) begin
            for (x = 1; x < GridCols - 1; x++) begin
               live = 0;
               for (dy = -1; dy <= 1; dy++) begin
                  for (dx = -1; dx <= 1; dx++) begin
                     if (dy != 0 || dx != 0) begin
                        live += prior[y + dy][x + dx];
                     end
                  end
               end
               if (prior[y][x]) begin
                  fresh[x] = (live == SurviveCount) || (live == BirthCount);
               end else begin
                  fresh[x] = (live == BirthCount);
               end
            end
         end
         life_rows[y] = fresh;
      end
      generation_tally++;
   endfunction

   // Applies one request word to the shadow grid and returns the response it earns.
   function automatic rsp_type apply_request(req_type word);
      rsp_type answer;
      answer.read_cells = '0;
      case (word.kind)
         KindWrite: begin
            life_rows[word.row_index] = word.row_cells;
         end
         KindStep: begin
            evolve_grid();
         end
         KindRead: begin
            answer.read_cells = life_rows[word.row_index];
         end
         default: begin
         end
      endcase
      answer.generation = generation_tally;
      return answer;
   endfunction

   // Both channels are sampled at the rising edge; the response is handled first so that
   // a response can never be matched against the request taken at the same edge.
   always @(posedge clock) begin
      rsp_type wanted;
      int y;
      if (reset) begin
         for (y = 0; y < GridRows; y++) begin
            life_rows[y] = '0;
         end
         generation_tally = '0;
         owed_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_words.size() == 0) begin
               $display("%0t: unexpected response word, read_cells %h generation %0d",
                        $time, rsp_data.read_cells, rsp_data.generation);
               error_count++;
            end else begin
               wanted = owed_words.pop_front();
               if (rsp_data.read_cells !== wanted.read_cells) begin
                  $display("%0t: read_cells mismatch, expected %h actual %h",
                           $time, wanted.read_cells, rsp_data.read_cells);
                  error_count++;
               end
               if (rsp_data.generation !== wanted.generation) begin
                  $display("%0t: generation mismatch, expected %0d actual %0d",
                           $time, wanted.generation, rsp_data.generation);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            owed_words.push_back(apply_request(req_data));
         end
      end
      pending_count <= owed_words.size();
   end

endmodule

### verif/life_automaton_engine_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the life automaton engine: clock, reset, request stimulus and the verdict.
module life_automaton_engine_core_tb;
   import lae_pkg::*;

   localparam logic [1:0] KindUnused = 2'd3;
   localparam int RandomWords = 650;
   localparam int StallLimit  = 2000;
   localparam int DrainCycles = 80;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int error_count;
   int pending_count;
   int idle_pct     = 24;
   int words_sent   = 0;
   int words_back   = 0;
   int quiet_cycles = 0;
   int kind_totals [4];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   life_automaton_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   life_automaton_engine_core_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // The receiver stalls at random, at the same rate as the sender idles.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   // Watchdog: ends the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         words_back <= words_back + 1;
      end
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("%0t: no word moved for %0d cycles", $time, StallLimit);
         $display("life_automaton_engine_core_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_word(logic [1:0] kind, logic [5:0] row,
                                         logic [63:0] cells);
      req_type word;
      word.kind      = kind;
      word.row_index = row;
      word.row_cells = cells;
      return word;
   endfunction

   // Random row contents, from sparse to dense.
   function automatic logic [63:0] random_row(int density);
      logic [63:0] a, b, c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case (density)
         0:       return a & b & c;
         1:       return a & b;
         2:       return a;
         default: return a | b;
      endcase
   endfunction

   // Offers one request word, with a random idle gap in front, and returns once it is taken.
   // All request signals change at the falling edge only.
   task automatic send_word(input req_type word);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data  = word;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      kind_totals[word.kind]++;
      words_sent++;
      // The no-idle stretch sits in the middle of the random part.
      idle_pct = (words_sent >= 300 && words_sent < 400) ? 0 : 24;
      @(negedge clock);
   endtask

   // Holds the sender back until every owed response has come.
   task automatic wait_for_responses();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Writes a band of random rows, steps 0 to 3 times, reads it back plus a row on each side.
   task automatic seed_band();
      int first_row, height, steps, density, i;
      first_row = $urandom_range(0, 63);
      height    = $urandom_range(1, 8);
      density   = $urandom_range(0, 3);
      steps     = $urandom_range(0, 3);
      for (i = 0; i < height; i++) begin
         send_word(make_word(KindWrite, 6'((first_row + i) % 64), random_row(density)));
      end
      for (i = 0; i < steps; i++) begin
         send_word(make_word(KindStep, 6'($urandom), {$urandom, $urandom}));
      end
      for (i = -1; i <= height; i++) begin
         send_word(make_word(KindRead, 6'((first_row + i + 64) % 64), {$urandom, $urandom}));
      end
   endtask

   // Places a glider at a random spot, lets it travel and reads where it went.
   task automatic launch_glider();
      int row, col, steps, i;
      row   = $urandom_range(0, 60);
      col   = $urandom_range(0, 61);
      steps = $urandom_range(1, 4);
      send_word(make_word(KindWrite, 6'(row),     64'h2 << col));
      send_word(make_word(KindWrite, 6'(row + 1), 64'h4 << col));
      send_word(make_word(KindWrite, 6'(row + 2), 64'h7 << col));
      for (i = 0; i < steps; i++) begin
         send_word(make_word(KindStep, '0, '0));
      end
      for (i = 0; i < 4; i++) begin
         send_word(make_word(KindRead, 6'((row + i) % 64), '0));
      end
   endtask

   // Anything at all, unused kind included.
   task automatic send_noise();
      send_word(make_word(2'($urandom_range(0, 3)), 6'($urandom), {$urandom, $urandom}));
   endtask

   initial begin
      int directed_count, pick;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: full rows on and next to the border, a step that must clear the
      // border, the unused kind, a blinker, and alternating column patterns.
      send_word(make_word(KindRead,  6'd0,  '0));
      send_word(make_word(KindWrite, 6'd0,  '1));
      send_word(make_word(KindWrite, 6'd63, '1));
      send_word(make_word(KindWrite, 6'd1,  '1));
      send_word(make_word(KindWrite, 6'd62, 64'h5555_5555_5555_5555));
      send_word(make_word(KindWrite, 6'd61, 64'haaaa_aaaa_aaaa_aaaa));
      send_word(make_word(KindRead,  6'd63, '0));
      send_word(make_word(KindRead,  6'd1,  '0));
      send_word(make_word(KindUnused, 6'd63, '1));
      send_word(make_word(KindStep,  6'd0,  '1));
      send_word(make_word(KindRead,  6'd0,  '0));
      send_word(make_word(KindRead,  6'd1,  '0));
      send_word(make_word(KindRead,  6'd2,  '0));
      send_word(make_word(KindRead,  6'd62, '0));
      send_word(make_word(KindRead,  6'd63, '0));
      send_word(make_word(KindWrite, 6'd11, 64'h7 << 19));
      send_word(make_word(KindStep,  6'd11, '0));
      send_word(make_word(KindRead,  6'd10, '0));
      send_word(make_word(KindRead,  6'd11, '0));
      send_word(make_word(KindRead,  6'd12, '0));
      send_word(make_word(KindStep,  6'd0,  '0));
      send_word(make_word(KindRead,  6'd11, '0));
      send_word(make_word(KindWrite, 6'd0,  '0));
      send_word(make_word(KindUnused, 6'd0, '0));
      directed_count = words_sent;
      wait_for_responses();

      // Random part: mostly seeded bands and gliders, with some noise in between.
      while (words_sent - directed_count < RandomWords) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            seed_band();
         end else if (pick < 75) begin
            launch_glider();
         end else if (pick < 97) begin
            send_noise();
         end else begin
            wait_for_responses();
         end
      end
      req_valid = 1'b0;

      wait_for_responses();
      repeat (DrainCycles) @(posedge clock);

      $display("Covered %0d row writes, %0d generation steps, %0d row reads,",
               kind_totals[KindWrite], kind_totals[KindStep], kind_totals[KindRead]);
      $display("and %0d unused-kind words; checked %0d response words against the grid.",
               kind_totals[KindUnused], words_back);
      if (error_count == 0) begin
         $display("life_automaton_engine_core_tb passed");
      end else begin
         $display("life_automaton_engine_core_tb failed");
      end
      $finish;
   end

endmodule

### files.f
src/lae_pkg.sv
src/lae_ram.sv
src/lae_row_unit.sv
src/life_automaton_engine_core.sv
verif/life_automaton_engine_core_checker.sv
verif/life_automaton_engine_core_tb.sv
